### sv/acsf_pkg.sv
// ----------------------------------------------------------------------------
// acsf_pkg
// Shared types and constants for the auto click-layer and scroll block.
// ----------------------------------------------------------------------------
package acsf_pkg;

    // request command codes
    localparam logic [1:0] CMD_MOTION = 2'd0;
    localparam logic [1:0] CMD_BUTTON = 2'd1;
    localparam logic [1:0] CMD_SCROLL = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    // mode codes as reported on the result
    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_WAITING   = 3'd1;
    localparam logic [2:0] MODE_CLICKABLE = 3'd2;
    localparam logic [2:0] MODE_CLICKING  = 3'd3;
    localparam logic [2:0] MODE_SCROLLING = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_ARM_DELAY    = 3'd0;
    localparam logic [2:0] CFG_IDLE_TIMEOUT = 3'd1;
    localparam logic [2:0] CFG_VERT_STEP    = 3'd2;
    localparam logic [2:0] CFG_HORIZ_STEP   = 3'd3;
    localparam logic [2:0] CFG_LOCK_DIST    = 3'd4;

    // configuration reset values
    localparam logic [15:0] RST_ARM_DELAY    = 16'd100;
    localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd800;
    localparam logic [14:0] RST_VERT_STEP    = 15'd50;
    localparam logic [14:0] RST_HORIZ_STEP   = 15'd50;
    localparam logic [14:0] RST_LOCK_DIST    = 15'd30;

    // misc constants
    localparam logic [15:0] WAIT_DROP_MS = 16'd50;
    localparam logic [2:0]  BUTTON_COUNT = 3'd5;
    localparam int          DIV_W        = 16;
    localparam int          DVS_W        = 15;

    // one-hot mode of the click layer machine
    typedef enum logic [4:0] {
        M_IDLE      = 5'b00001,
        M_WAIT      = 5'b00010,
        M_CLICKABLE = 5'b00100,
        M_CLICKING  = 5'b01000,
        M_SCROLL    = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [1:0]        cmd;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic [2:0]        button_index;
        logic              pressed;
    } t_req;

    typedef struct packed {
        logic signed [7:0] out_x;
        logic signed [7:0] out_y;
        logic signed [7:0] out_h;
        logic signed [7:0] out_v;
        logic [4:0]        button_bits;
        logic              layer_active;
        logic [2:0]        mode_now;
    } t_rsp;

    // commands from controller to datapath
    typedef struct packed {
        logic       tick;
        logic       btn;
        logic       load_budget;
        logic       click_motion;
        logic       clr_elapsed;
        logic       set_layer;
        logic       dis_layer;
        logic       scroll_cap;
        logic       div_start;
        logic       fin;
        logic       out_direct;
        logic [2:0] mode_code;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic motion;
        logic gt_arm;
        logic gt_idle;
        logic gt_drop;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

### sv/acsf_if.sv
// ----------------------------------------------------------------------------
// acsf_if
// Valid/ready channels for requests and results of the click-layer block.
// ----------------------------------------------------------------------------
interface acsf_req_if;
    import acsf_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface acsf_rsp_if;
    import acsf_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/acsf_div.sv
// ----------------------------------------------------------------------------
// acsf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acsf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [acsf_pkg::DIV_W-1:0] i_dividend,
    input  logic [acsf_pkg::DVS_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [acsf_pkg::DIV_W-1:0] o_quotient,
    output logic [acsf_pkg::DVS_W-1:0] o_remainder
);
    import acsf_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   w_shift;
    logic [DVS_W+1:0] w_diff;

    // trial subtract of the shifted partial remainder
    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // datapath of the divider
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[DVS_W+1]) begin
                r_rem <= w_diff[DVS_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DVS_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    // checks
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not start");
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_dvs != '0) |-> (o_remainder < r_dvs))
        else $error("divider remainder not below divisor");

endmodule

### sv/acsf_ctrl.sv
// ----------------------------------------------------------------------------
// acsf_ctrl
// Request sequencer and click-layer mode machine.
// ----------------------------------------------------------------------------
module acsf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  acsf_pkg::t_req     i_req,
    input  acsf_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output acsf_pkg::t_dp_cmd  o_cmd
);
    import acsf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_seq;

    t_seq    r_seq, n_seq;
    t_mode   r_mode, n_mode;
    t_dp_cmd w_cmd;
    logic    w_take;

    assign o_in_ready = (r_seq == S_IDLE) && i_stat.out_free;
    assign w_take     = i_in_valid && o_in_ready;

    // next state and datapath commands
    always_comb begin
        n_seq  = r_seq;
        n_mode = r_mode;
        w_cmd  = '0;
        case (r_seq)
            S_IDLE: begin
                if (w_take) begin
                    case (i_req.cmd)
                        CMD_MOTION: begin
                            if (i_stat.motion) begin
                                case (r_mode)
                                    M_CLICKABLE: w_cmd.clr_elapsed = 1'b1;
                                    M_CLICKING:  w_cmd.click_motion = 1'b1;
                                    M_SCROLL: begin
                                        w_cmd.scroll_cap = 1'b1;
                                        n_seq = S_LOAD;
                                    end
                                    M_WAIT: begin
                                        if (i_stat.gt_arm) begin
                                            w_cmd.clr_elapsed = 1'b1;
                                            w_cmd.set_layer   = 1'b1;
                                            n_mode = M_CLICKABLE;
                                        end
                                    end
                                    default: begin
                                        w_cmd.clr_elapsed = 1'b1;
                                        n_mode = M_WAIT;
                                    end
                                endcase
                            end else begin
                                case (r_mode)
                                    M_CLICKABLE: begin
                                        if (i_stat.gt_idle) begin
                                            w_cmd.dis_layer = 1'b1;
                                            n_mode = M_IDLE;
                                        end
                                    end
                                    M_WAIT: begin
                                        if (i_stat.gt_drop) begin
                                            n_mode = M_IDLE;
                                        end
                                    end
                                    M_CLICKING, M_SCROLL: begin
                                        n_mode = r_mode;
                                    end
                                    default: n_mode = M_IDLE;
                                endcase
                            end
                        end
                        CMD_BUTTON: begin
                            if (i_req.button_index < BUTTON_COUNT) begin
                                w_cmd.btn = 1'b1;
                                if (i_req.pressed) begin
                                    w_cmd.load_budget = 1'b1;
                                    n_mode = M_CLICKING;
                                end else begin
                                    w_cmd.clr_elapsed = 1'b1;
                                    w_cmd.set_layer   = 1'b1;
                                    n_mode = M_CLICKABLE;
                                end
                            end
                        end
                        CMD_SCROLL: begin
                            if (i_req.pressed) begin
                                n_mode = M_SCROLL;
                            end else begin
                                w_cmd.clr_elapsed = 1'b1;
                                w_cmd.set_layer   = 1'b1;
                                n_mode = M_CLICKABLE;
                            end
                        end
                        default: w_cmd.tick = 1'b1;
                    endcase
                    w_cmd.out_direct = !w_cmd.scroll_cap;
                end
            end
            S_LOAD: begin
                w_cmd.div_start = 1'b1;
                n_seq = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_seq = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    w_cmd.fin = 1'b1;
                    n_seq = S_IDLE;
                end
            end
            default: n_seq = S_IDLE;
        endcase

        // reported mode after this request
        case (n_mode)
            M_WAIT:      w_cmd.mode_code = MODE_WAITING;
            M_CLICKABLE: w_cmd.mode_code = MODE_CLICKABLE;
            M_CLICKING:  w_cmd.mode_code = MODE_CLICKING;
            M_SCROLL:    w_cmd.mode_code = MODE_SCROLLING;
            default:     w_cmd.mode_code = MODE_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq  <= S_IDLE;
            r_mode <= M_IDLE;
        end else begin
            r_seq  <= n_seq;
            r_mode <= n_mode;
        end
    end

    assign o_cmd = w_cmd;

    // checks
    a_scroll_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scroll_cap |=> (r_seq == S_LOAD))
        else $error("scroll request did not start the step count");
    a_div_in_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> (r_mode == M_SCROLL))
        else $error("step count started outside scrolling");
    a_fin_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == S_FIN && i_stat.out_free) |=> (r_seq == S_IDLE))
        else $error("scroll result not delivered");

endmodule

### sv/acsf_dp.sv
// ----------------------------------------------------------------------------
// acsf_dp
// Datapath: configuration, timers, lock budget, scroll accumulators, result.
// ----------------------------------------------------------------------------
module acsf_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  acsf_pkg::t_req     i_req,
    input  acsf_pkg::t_dp_cmd  i_cmd,
    output acsf_pkg::t_dp_stat o_stat,
    acsf_rsp_if.source         o_rsp
);
    import acsf_pkg::*;

    // configuration
    logic [15:0] r_arm_delay;
    logic [15:0] r_idle_timeout;
    logic [14:0] r_vert_step;
    logic [14:0] r_horiz_step;
    logic [14:0] r_lock_dist;

    // state
    logic [15:0] r_elapsed;
    logic [15:0] r_budget, n_budget;
    logic [16:0] r_vacc;
    logic [16:0] r_hacc;
    logic [4:0]  r_held, n_held;
    logic        r_layer, n_layer;
    logic [16:0] r_sum;
    logic        r_vert;
    logic        r_out_valid;
    t_rsp        r_out;

    logic [7:0]  w_dx, w_dy, w_abs_x, w_abs_y, w_sat_x, w_sat_y;
    logic [8:0]  w_mag;
    logic [16:0] w_bdiff;
    logic        w_budget_pos;
    logic        w_vert_axis;
    logic [4:0]  w_bit;
    logic [16:0] w_neg_sum;
    logic [15:0] w_sum_mag;
    logic [14:0] w_step, w_t;
    logic [15:0] w_dividend;
    logic        w_a_gt_t;
    logic        w_div_done;
    logic [15:0] w_quo;
    logic [14:0] w_rem;
    logic [15:0] w_n;
    logic [7:0]  w_nsat, w_nneg;
    logic [15:0] w_new_mag;
    logic [16:0] w_new_acc;
    logic        w_out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_delay    <= RST_ARM_DELAY;
            r_idle_timeout <= RST_IDLE_TIMEOUT;
            r_vert_step    <= RST_VERT_STEP;
            r_horiz_step   <= RST_HORIZ_STEP;
            r_lock_dist    <= RST_LOCK_DIST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ARM_DELAY:    r_arm_delay    <= i_cfg_data;
                CFG_IDLE_TIMEOUT: r_idle_timeout <= i_cfg_data;
                CFG_VERT_STEP:    r_vert_step    <= i_cfg_data[14:0];
                CFG_HORIZ_STEP:   r_horiz_step   <= i_cfg_data[14:0];
                CFG_LOCK_DIST:    r_lock_dist    <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // motion magnitudes and pass-through saturation
    assign w_dx    = i_req.dx;
    assign w_dy    = i_req.dy;
    assign w_abs_x = w_dx[7] ? (8'd0 - w_dx) : w_dx;
    assign w_abs_y = w_dy[7] ? (8'd0 - w_dy) : w_dy;
    assign w_sat_x = (w_dx == 8'h80) ? 8'h81 : w_dx;
    assign w_sat_y = (w_dy == 8'h80) ? 8'h81 : w_dy;
    assign w_mag   = {1'b0, w_abs_x} + {1'b0, w_abs_y};

    // lock budget with floor at the most negative value
    assign w_bdiff = {r_budget[15], r_budget} - {8'd0, w_mag};
    always_comb begin
        if (i_cmd.load_budget) begin
            n_budget = {1'b0, r_lock_dist};
        end else if (i_cmd.click_motion) begin
            n_budget = (w_bdiff[16] && !w_bdiff[15]) ? 16'h8000 : w_bdiff[15:0];
        end else begin
            n_budget = r_budget;
        end
    end
    assign w_budget_pos = !n_budget[15] && (n_budget != 16'd0);

    // held buttons and layer flag
    assign w_bit = 5'd1 << i_req.button_index;
    always_comb begin
        n_held = r_held;
        if (i_cmd.btn) begin
            n_held = i_req.pressed ? (r_held | w_bit) : (r_held & ~w_bit);
        end
        n_layer = r_layer;
        if (i_cmd.set_layer) begin
            n_layer = 1'b1;
        end else if (i_cmd.dis_layer) begin
            n_layer = 1'b0;
        end
    end

    // scroll axis choice, vertical weighted twice
    assign w_vert_axis = {w_abs_y, 1'b0} > {1'b0, w_abs_x};

    // divider operands from the captured sum
    assign w_neg_sum  = 17'd0 - r_sum;
    assign w_sum_mag  = r_sum[16] ? w_neg_sum[15:0] : r_sum[15:0];
    assign w_step     = r_vert ? r_vert_step : r_horiz_step;
    assign w_t        = (w_step == 15'd0) ? 15'd1 : w_step;
    assign w_dividend = (w_sum_mag == 16'd0) ? 16'd0 : (w_sum_mag - 16'd1);
    assign w_a_gt_t   = w_sum_mag > {1'b0, w_t};

    acsf_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_t),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // step count and reduced accumulator
    assign w_n       = w_a_gt_t ? w_quo : 16'd0;
    assign w_nsat    = (w_n > 16'd127) ? 8'd127 : {1'b0, w_n[6:0]};
    assign w_nneg    = 8'd0 - w_nsat;
    assign w_new_mag = w_a_gt_t ? ({1'b0, w_rem} + 16'd1) : w_sum_mag;
    assign w_new_acc = r_sum[16] ? (17'd0 - {1'b0, w_new_mag}) : {1'b0, w_new_mag};

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_budget  <= '0;
            r_vacc    <= '0;
            r_hacc    <= '0;
            r_held    <= '0;
            r_layer   <= 1'b0;
        end else begin
            if (i_cmd.clr_elapsed) begin
                r_elapsed <= '0;
            end else if (i_cmd.tick && r_elapsed != 16'hFFFF) begin
                r_elapsed <= r_elapsed + 16'd1;
            end
            r_budget <= n_budget;
            r_held   <= n_held;
            r_layer  <= n_layer;
            if (i_cmd.dis_layer) begin
                r_vacc <= '0;
                r_hacc <= '0;
            end else if (i_cmd.fin) begin
                if (r_vert) begin
                    r_vacc <= w_new_acc;
                end else begin
                    r_hacc <= w_new_acc;
                end
            end
        end
    end

    // capture of the accumulated sum for a scroll request
    always_ff @(posedge i_clk) begin
        if (i_cmd.scroll_cap) begin
            r_vert <= w_vert_axis;
            r_sum  <= w_vert_axis ? (r_vacc + {{9{w_dy[7]}}, w_dy})
                                  : (r_hacc + {{9{w_dx[7]}}, w_dx});
        end
    end

    // result register
    assign w_out_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_direct || i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_direct) begin
            if (i_req.cmd == CMD_MOTION && !(i_cmd.click_motion && w_budget_pos)) begin
                r_out.out_x <= w_sat_x;
                r_out.out_y <= w_sat_y;
            end else begin
                r_out.out_x <= '0;
                r_out.out_y <= '0;
            end
            r_out.out_h        <= '0;
            r_out.out_v        <= '0;
            r_out.button_bits  <= n_held;
            r_out.layer_active <= n_layer;
            r_out.mode_now     <= i_cmd.mode_code;
        end else if (i_cmd.fin) begin
            r_out.out_x        <= '0;
            r_out.out_y        <= '0;
            r_out.out_h        <= r_vert ? 8'd0 : (r_sum[16] ? w_nneg : w_nsat);
            r_out.out_v        <= r_vert ? (r_sum[16] ? w_nsat : w_nneg) : 8'd0;
            r_out.button_bits  <= n_held;
            r_out.layer_active <= n_layer;
            r_out.mode_now     <= i_cmd.mode_code;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // status to the controller
    assign o_stat.motion   = (w_dx != 8'd0) || (w_dy != 8'd0);
    assign o_stat.gt_arm   = r_elapsed > r_arm_delay;
    assign o_stat.gt_idle  = r_elapsed > r_idle_timeout;
    assign o_stat.gt_drop  = r_elapsed > WAIT_DROP_MS;
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = w_out_free;

    // checks
    a_cursor_or_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.out_x != 8'sd0 || r_out.out_y != 8'sd0))
            |-> (r_out.out_h == 8'sd0 && r_out.out_v == 8'sd0))
        else $error("cursor motion and scroll steps in one result");
    a_fin_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> !i_cmd.fin)
        else $error("scroll result written before the step count");

endmodule

### sv/auto_mouse_click_scroll_fsm.sv
// ----------------------------------------------------------------------------
// auto_mouse_click_scroll_fsm
// Auto click layer and scroll engine for a trackball pointing device.
// ----------------------------------------------------------------------------
// Usage:
//  - i_req carries one request per handshake: a motion report, a mouse-button
//    event, a scroll-key event or a millisecond tick. o_rsp returns exactly
//    one result per request: passed-on cursor motion, scroll steps, held
//    buttons, layer flag and current mode.
//  - i_cfg_we/i_cfg_idx/i_cfg_data write the five configuration registers;
//    write them only while no request is in flight.
//  - A motion report in scrolling mode goes from accept to a valid result
//    through capture, divider load, the 16-step restoring divider, the
//    divider done flag and the result write; every other request shows its
//    result in the cycle after accept.
//  - Throughput: one request per cycle for non-scroll requests while the
//    result register drains; one request in flight at a time.
//  - Reset (synchronous, active low) restores configuration defaults, puts
//    the mode machine in idle and clears timers, budget and accumulators.
//  - When the receiver stalls, the result register holds and the block stops
//    taking requests until the result is taken.
// ----------------------------------------------------------------------------
module auto_mouse_click_scroll_fsm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    acsf_req_if.sink    i_req,
    acsf_rsp_if.source  o_rsp
);
    import acsf_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    assign i_req.ready = w_in_ready;

    // mode machine and request sequencer
    acsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_req      (i_req.data),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // timers, budget, accumulators and result register
    acsf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req.data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_rsp      (o_rsp)
    );

endmodule

### tb/acsf_scorer.sv
// ----------------------------------------------------------------------------
// acsf_scorer
// Watches the request, result and configuration ports of the click-layer
// block. It keeps its own copy of the mode machine, timers, budget and
// scroll sums, works out the result of every accepted request, and compares
// each accepted result field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module acsf_scorer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    acsf_req_if         i_req,
    acsf_rsp_if         i_rsp,
    output int          o_err_cnt,
    output int          o_pending
);
    import acsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // shadow configuration
    logic [15:0] cfg_arm;
    logic [15:0] cfg_idle;
    logic [14:0] cfg_vstep;
    logic [14:0] cfg_hstep;
    logic [14:0] cfg_lock;

    // shadow state
    logic [2:0]  cur_mode;
    logic [15:0] ms_count;
    int          freeze_left;
    int          v_sum;
    int          h_sum;
    logic [4:0]  btn_held;
    logic        layer_up;

    t_rsp        report_q[$];
    int          rsp_seen;

    function automatic void reset_model();
        cfg_arm     = RST_ARM_DELAY;
        cfg_idle    = RST_IDLE_TIMEOUT;
        cfg_vstep   = RST_VERT_STEP;
        cfg_hstep   = RST_HORIZ_STEP;
        cfg_lock    = RST_LOCK_DIST;
        cur_mode    = MODE_IDLE;
        ms_count    = '0;
        freeze_left = 0;
        v_sum       = 0;
        h_sum       = 0;
        btn_held    = '0;
        layer_up    = 1'b0;
    endfunction

    function automatic void raise_layer();
        layer_up = 1'b1;
        ms_count = '0;
        cur_mode = MODE_CLICKABLE;
    endfunction

    function automatic void drop_layer();
        cur_mode = MODE_IDLE;
        layer_up = 1'b0;
        v_sum    = 0;
        h_sum    = 0;
    endfunction

    function automatic logic [7:0] clip8(input int val);
        if (val > 127) return 8'sd127;
        if (val < -127) return -8'sd127;
        return 8'(val);
    endfunction

    // whole steps taken out of a scroll sum, remainder left behind
    function automatic int scroll_steps(input int sum, input logic [14:0] step_reg,
                                        output int left);
        int thr;
        int mag;
        int n;
        thr  = (step_reg == '0) ? 1 : int'(step_reg);
        mag  = (sum < 0) ? -sum : sum;
        left = sum;
        if (mag <= thr) return 0;
        n = (mag - 1) / thr;
        if (sum < 0) begin
            left = sum + n * thr;
            return -n;
        end
        left = sum - n * thr;
        return n;
    endfunction

    // result of one request, advancing the shadow state
    function automatic t_rsp next_report(input t_req r);
        int   x;
        int   y;
        int   h;
        int   v;
        int   ax;
        int   ay;
        int   left;
        t_rsp o;
        x    = 0;
        y    = 0;
        h    = 0;
        v    = 0;
        left = 0;
        case (r.cmd)
            CMD_MOTION: begin
                x  = int'($signed(r.dx));
                y  = int'($signed(r.dy));
                ax = (x < 0) ? -x : x;
                ay = (y < 0) ? -y : y;
                if (x != 0 || y != 0) begin
                    case (cur_mode)
                        MODE_CLICKABLE: ms_count = '0;
                        MODE_CLICKING: begin
                            freeze_left = freeze_left - (ax + ay);
                            if (freeze_left < -32768) freeze_left = -32768;
                            if (freeze_left > 0) begin
                                x = 0;
                                y = 0;
                            end
                        end
                        MODE_SCROLLING: begin
                            // vertical wins at twice the weight
                            if (ay * 2 > ax) begin
                                v     = -scroll_steps(v_sum + y, cfg_vstep, left);
                                v_sum = left;
                            end else begin
                                h     = scroll_steps(h_sum + x, cfg_hstep, left);
                                h_sum = left;
                            end
                            x = 0;
                            y = 0;
                        end
                        MODE_WAITING: if (ms_count > cfg_arm) raise_layer();
                        default: begin
                            ms_count = '0;
                            cur_mode = MODE_WAITING;
                        end
                    endcase
                end else begin
                    // no motion: timeout checks only
                    case (cur_mode)
                        MODE_CLICKING, MODE_SCROLLING: begin
                        end
                        MODE_CLICKABLE: if (ms_count > cfg_idle) drop_layer();
                        MODE_WAITING: if (ms_count > WAIT_DROP_MS) cur_mode = MODE_IDLE;
                        default: cur_mode = MODE_IDLE;
                    endcase
                end
            end
            CMD_BUTTON: begin
                if (r.button_index < BUTTON_COUNT) begin
                    if (r.pressed) begin
                        btn_held    = btn_held | (5'd1 << r.button_index);
                        cur_mode    = MODE_CLICKING;
                        freeze_left = int'(cfg_lock);
                    end else begin
                        btn_held = btn_held & ~(5'd1 << r.button_index);
                        raise_layer();
                    end
                end
            end
            CMD_SCROLL: begin
                if (r.pressed) cur_mode = MODE_SCROLLING;
                else raise_layer();
            end
            default: if (ms_count != 16'hFFFF) ms_count = ms_count + 16'd1;
        endcase
        o.out_x        = clip8(x);
        o.out_y        = clip8(y);
        o.out_h        = clip8(h);
        o.out_v        = clip8(v);
        o.button_bits  = btn_held;
        o.layer_active = layer_up;
        o.mode_now     = cur_mode;
        return o;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("acsf_scorer: result %0d: %s", rsp_seen, msg);
        o_err_cnt = o_err_cnt + 1;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) note_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // watch the ports at every edge
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            reset_model();
            report_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ARM_DELAY:    cfg_arm   = i_cfg_data;
                    CFG_IDLE_TIMEOUT: cfg_idle  = i_cfg_data;
                    CFG_VERT_STEP:    cfg_vstep = i_cfg_data[14:0];
                    CFG_HORIZ_STEP:   cfg_hstep = i_cfg_data[14:0];
                    CFG_LOCK_DIST:    cfg_lock  = i_cfg_data[14:0];
                    default: begin
                    end
                endcase
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.data;
                if (report_q.size() == 0) begin
                    note_mismatch("result with no request outstanding");
                end else begin
                    want = report_q.pop_front();
                    check_field("out_x", int'($signed(got.out_x)), int'($signed(want.out_x)));
                    check_field("out_y", int'($signed(got.out_y)), int'($signed(want.out_y)));
                    check_field("out_h", int'($signed(got.out_h)), int'($signed(want.out_h)));
                    check_field("out_v", int'($signed(got.out_v)), int'($signed(want.out_v)));
                    check_field("button_bits", int'(got.button_bits),
                                int'(want.button_bits));
                    check_field("layer_active", int'(got.layer_active),
                                int'(want.layer_active));
                    check_field("mode_now", int'(got.mode_now), int'(want.mode_now));
                end
                rsp_seen = rsp_seen + 1;
            end
            if (i_req.valid && i_req.ready) report_q.push_back(next_report(i_req.data));
            o_pending <= report_q.size();
        end
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the auto click-layer and scroll block. Drives
// directed requests at reset, lowest and highest settings (with long motion
// runs to reach the budget and threshold limits), then random episodes of
// wandering, clicking, scrolling and noise under random settings, with
// random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
    import acsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [15:0] cfg_data;
    int          err_cnt;
    int          pending;
    int          sent;
    bit          calm;

    acsf_req_if req_ch ();
    acsf_rsp_if rsp_ch ();

    auto_mouse_click_scroll_fsm u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    acsf_scorer u_scorer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .i_rsp      (rsp_ch),
        .o_err_cnt  (err_cnt),
        .o_pending  (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int pick_gap();
        if (calm) return 0;
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [7:0] rnd_s8(input int lim);
        return 8'(int'($urandom_range(0, 2 * lim)) - lim);
    endfunction

    function automatic t_req rand_req();
        t_req r;
        r.cmd          = 2'($urandom_range(0, 3));
        r.dx           = rnd_s8(127);
        r.dy           = rnd_s8(127);
        r.button_index = 3'($urandom_range(0, 7));
        r.pressed      = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic logic [2:0] pick_button();
        if ($urandom_range(0, 9) == 0) return 3'($urandom_range(BUTTON_COUNT, 7));
        return 3'($urandom_range(0, BUTTON_COUNT - 1));
    endfunction

    function automatic logic [15:0] pick_ms(input int typical);
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, typical));
        endcase
    endfunction

    function automatic logic [15:0] pick_15(input int lo, input int typical);
        logic [14:0] val;
        case ($urandom_range(0, 9))
            0: val = 15'd0;
            1: val = 15'h7FFF;
            2: val = 15'($urandom_range(0, 32767));
            default: val = 15'($urandom_range(lo, typical));
        endcase
        return {1'($urandom_range(0, 1)), val};
    endfunction

    // one request: random gap, then hold valid until accepted
    task automatic send_req(input t_req r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        if (!(r.cmd == CMD_BUTTON && r.button_index >= BUTTON_COUNT)) sent++;
    endtask

    task automatic motion(input logic [7:0] dx, input logic [7:0] dy);
        t_req r;
        r     = rand_req();
        r.cmd = CMD_MOTION;
        r.dx  = dx;
        r.dy  = dy;
        send_req(r);
    endtask

    task automatic button(input logic [2:0] idx, input logic p);
        t_req r;
        r              = rand_req();
        r.cmd          = CMD_BUTTON;
        r.button_index = idx;
        r.pressed      = p;
        send_req(r);
    endtask

    task automatic scroll(input logic p);
        t_req r;
        r         = rand_req();
        r.cmd     = CMD_SCROLL;
        r.pressed = p;
        send_req(r);
    endtask

    task automatic tick();
        t_req r;
        r     = rand_req();
        r.cmd = CMD_TICK;
        send_req(r);
    endtask

    task automatic motion_rand();
        int lim;
        if ($urandom_range(0, 7) == 0) begin
            motion(8'd0, 8'd0);
        end else begin
            lim = ($urandom_range(0, 1) == 1) ? 127 : 8;
            motion(rnd_s8(lim), rnd_s8(lim));
        end
    endtask

    // stop requests and wait for every result
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [15:0] arm, input logic [15:0] idle,
                            input logic [15:0] vstep, input logic [15:0] hstep,
                            input logic [15:0] lock, input bit junk);
        drain();
        cfg_write(CFG_ARM_DELAY, arm);
        cfg_write(CFG_IDLE_TIMEOUT, idle);
        cfg_write(CFG_VERT_STEP, vstep);
        cfg_write(CFG_HORIZ_STEP, hstep);
        cfg_write(CFG_LOCK_DIST, lock);
        if (junk) cfg_write(CFG_LOCK_DIST + 3'($urandom_range(1, 3)),
                            16'($urandom_range(0, 65535)));
        cfg_we <= 1'b0;
    endtask

    // one random episode of use
    task automatic random_episode();
        logic [2:0] b1;
        logic [2:0] b2;
        b1 = pick_button();
        b2 = pick_button();
        case ($urandom_range(0, 9))
            0, 1: repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 1) == 1) motion_rand();
                else repeat ($urandom_range(0, 8)) tick();
            end
            2, 3: begin
                button(b1, 1'b1);
                repeat ($urandom_range(0, 8)) motion_rand();
                if ($urandom_range(0, 3) == 0) tick();
                button(($urandom_range(0, 3) == 0) ? b2 : b1, 1'b0);
            end
            4, 5: begin
                scroll(1'b1);
                repeat ($urandom_range(1, 12)) motion_rand();
                scroll(1'b0);
            end
            6: repeat ($urandom_range(1, 5)) begin
                repeat ($urandom_range(0, 20)) tick();
                motion(8'd0, 8'd0);
            end
            7: repeat (3) send_req(rand_req());
            8: begin
                button(b1, 1'b1);
                button(b2, 1'b1);
                motion_rand();
                button(b2, 1'b0);
                button(b1, 1'b0);
            end
            default: begin
                repeat ($urandom_range(20, 60)) tick();
                motion_rand();
                motion(8'd0, 8'd0);
            end
        endcase
    endtask

    // result side: random stall before each result
    initial begin
        int gap;
        rsp_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    // request side and verdict
    initial begin
        int goal;
        sent         = 0;
        calm         = 1'b0;
        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= CFG_ARM_DELAY;
        cfg_data     <= '0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: wait, click with budget, scroll both axes
        motion(8'sd127, -8'sd127);
        motion(8'd0, 8'd0);
        tick();
        button(3'd0, 1'b1);
        motion(8'sd10, 8'sd5);
        motion(8'sd127, 8'sd127);
        motion(8'd0, 8'd0);
        button(3'd4, 1'b1);
        button(BUTTON_COUNT + 3'd2, 1'b1);
        button(BUTTON_COUNT, 1'b0);
        button(3'd0, 1'b0);
        scroll(1'b1);
        motion(8'd0, 8'sd127);
        motion(-8'sd127, -8'sd60);
        motion(-8'sd127, -8'sd64);
        motion(8'd0, 8'd0);
        scroll(1'b0);
        button(3'd4, 1'b0);

        // lowest settings, zero scroll steps act as one
        set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        scroll(1'b1);
        motion(8'sd127, 8'sd127);
        motion(-8'sd127, 8'd0);
        scroll(1'b0);
        tick();
        motion(8'd0, 8'd0);
        motion(8'sd1, 8'd0);
        tick();
        motion(8'd0, -8'sd1);
        button(3'd2, 1'b1);
        motion(8'sd1, 8'd0);
        button(3'd2, 1'b0);

        // highest settings: budget floor, widest steps
        calm = 1'b1;
        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        motion(8'sd5, 8'sd5);
        repeat (40) tick();
        motion(8'sd1, 8'sd1);
        motion(8'd0, 8'd0);
        button(3'd1, 1'b1);
        repeat (270) motion(8'sd127, 8'sd127);
        button(3'd1, 1'b0);
        repeat (3) tick();
        motion(8'd0, 8'd0);
        scroll(1'b1);
        repeat (270) motion(8'd0, 8'sd127);
        repeat (270) motion(8'sd127, 8'd0);
        scroll(1'b0);
        calm = 1'b0;

        // random episodes under random settings
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph % 3 == 2);
            set_regs(pick_ms(12), pick_ms(40), pick_15(1, 120), pick_15(1, 120),
                     pick_15(0, 300), 1'b1);
            goal = sent + 100;
            while (sent < goal) random_episode();
        end
        calm = 1'b0;

        drain();
        repeat (40) @(posedge i_clk);
        if (err_cnt == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
sv/acsf_pkg.sv
sv/acsf_if.sv
sv/acsf_div.sv
sv/acsf_ctrl.sv
sv/acsf_dp.sv
sv/auto_mouse_click_scroll_fsm.sv
tb/acsf_scorer.sv
tb/tb.sv
